// ----- rtl/utf16_xml_char_ref_escaper_defines.svh -----
// Assertion macros shared by the checker of the character reference escaper.
// Depends on nothing; every macro takes the clock and the active-low reset.
`ifndef UTF16_XML_CHAR_REF_ESCAPER_DEFINES_SVH
`define UTF16_XML_CHAR_REF_ESCAPER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U16ESC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define U16ESC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/u16esc_pkg.sv -----
// Shared types, character constants and lookup functions of the escaper.
// Used by the controller, the datapath, the top level and the checker.
`timescale 1ns / 1ps

package u16esc_pkg;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned NDIG   = 7;

  localparam logic [CP_W-1:0] CP_REPL      = 21'h00FFFD;
  localparam logic [CP_W-1:0] CP_SUPP_BASE = 21'h010000;
  localparam logic [CP_W-1:0] CP_DEL       = 21'd127;
  localparam logic [CP_W-1:0] CP_SPACE     = 21'd32;

  // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every x below 2**22.
  localparam logic [CP_W-1:0] RECIP_10    = 21'd1677722;
  localparam int unsigned     RECIP_SHIFT = 24;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;

  localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};
  localparam logic [47:0] ENT_QUOT = "&quot;";

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_NUM
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_CONV,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic load;       // capture the accepted word
    logic adv;        // move the queued code point into the working slot
    logic conv_init;  // start the decimal conversion
    logic conv_step;  // produce one more decimal digit
    logic emit;       // write one output byte
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  nxt_valid;
    logic  conv_last;
    logic  cp_done;
    logic  out_free;
  } dp_stat_t;

  function automatic kind_e classify(logic [CP_W-1:0] cp);
    kind_e k;
    if (cp == 21'(CH_AMP)) begin
      k = KIND_AMP;
    end else if (cp == 21'(CH_LT)) begin
      k = KIND_LT;
    end else if (cp == 21'(CH_GT)) begin
      k = KIND_GT;
    end else if (cp == 21'(CH_QUOT)) begin
      k = KIND_QUOT;
    end else if (cp < CP_SPACE || cp == CP_DEL) begin
      k = KIND_NONE;
    end else begin
      k = KIND_NUM;
    end
    return k;
  endfunction

  function automatic logic [7:0] ent_byte(kind_e k, logic [2:0] p);
    logic [47:0] s;
    logic [7:0]  b;
    case (k)
      KIND_AMP: s = ENT_AMP;
      KIND_LT:  s = ENT_LT;
      KIND_GT:  s = ENT_GT;
      default:  s = ENT_QUOT;
    endcase
    case (p)
      3'd0:    b = s[47:40];
      3'd1:    b = s[39:32];
      3'd2:    b = s[31:24];
      3'd3:    b = s[23:16];
      3'd4:    b = s[15:8];
      default: b = s[7:0];
    endcase
    return b;
  endfunction

  function automatic logic ent_last(kind_e k, logic [2:0] p);
    logic l;
    case (k)
      KIND_AMP: l = (p == 3'd4);
      KIND_LT:  l = (p == 3'd3);
      KIND_GT:  l = (p == 3'd3);
      default:  l = (p == 3'd5);
    endcase
    return l;
  endfunction

endpackage

// ----- rtl/u16esc_ctrl.sv -----
// Sequencer of the escaper: accepts words and steps the datapath through
// decoding, decimal conversion and byte output. Depends on u16esc_pkg.
`timescale 1ns / 1ps

module u16esc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  u16esc_pkg::dp_stat_t  stat_i,
  output u16esc_pkg::ctrl_cmd_t cmd_o
);

  u16esc_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u16esc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      u16esc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = u16esc_pkg::ST_START;
        end
      end
      u16esc_pkg::ST_START: begin
        if (stat_i.kind == u16esc_pkg::KIND_NONE) begin
          // A silent code point yields nothing; go on to the queued one if any.
          if (stat_i.nxt_valid) begin
            cmd_o.adv = 1'b1;
          end else begin
            state_d = u16esc_pkg::ST_IDLE;
          end
        end else if (stat_i.kind == u16esc_pkg::KIND_NUM) begin
          cmd_o.conv_init = 1'b1;
          state_d         = u16esc_pkg::ST_CONV;
        end else begin
          state_d = u16esc_pkg::ST_EMIT;
        end
      end
      u16esc_pkg::ST_CONV: begin
        cmd_o.conv_step = 1'b1;
        if (stat_i.conv_last) begin
          state_d = u16esc_pkg::ST_EMIT;
        end
      end
      u16esc_pkg::ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.cp_done) begin
            if (stat_i.nxt_valid) begin
              cmd_o.adv = 1'b1;
              state_d   = u16esc_pkg::ST_START;
            end else begin
              state_d = u16esc_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = u16esc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/u16esc_dpath.sv -----
// Datapath of the escaper: surrogate pairing, code point queue, divide-by-ten
// digit extraction, byte selection and the output register. Uses u16esc_pkg.
`timescale 1ns / 1ps

module u16esc_dpath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [15:0]           code_unit_i,
  input  logic                  end_of_string_i,
  input  u16esc_pkg::ctrl_cmd_t cmd_i,
  output u16esc_pkg::dp_stat_t  stat_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_run_o
);

  localparam int unsigned CW = u16esc_pkg::CP_W;
  localparam int unsigned QW = CW - 3;

  logic          pend_valid_q, pend_valid_d;
  logic [9:0]    pend_bits_q, pend_bits_d;
  logic          nxt_valid_q, nxt_valid_d;
  logic [15:0]   nxt_cp_q, nxt_cp_d;
  logic [CW-1:0] cur_cp_q, cur_cp_d;
  logic [CW-1:0] work_q;
  logic [3:0]    dig_q [u16esc_pkg::NDIG];
  logic [2:0]    ndig_q;
  logic [3:0]    pos_q;
  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  logic          out_last_q;

  logic is_high, is_low;
  assign is_high = (code_unit_i[15:10] == 6'b110110);
  assign is_low  = (code_unit_i[15:10] == 6'b110111);

  // Decide at acceptance which code points this word produces, in order.
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_bits_d  = pend_bits_q;
    nxt_valid_d  = 1'b0;
    nxt_cp_d     = code_unit_i;
    cur_cp_d     = {5'b0, code_unit_i};
    if (pend_valid_q) begin
      pend_valid_d = 1'b0;
      pend_bits_d  = '0;
      if (is_low) begin
        cur_cp_d = u16esc_pkg::CP_SUPP_BASE + {1'b0, pend_bits_q, code_unit_i[9:0]};
      end else begin
        cur_cp_d = u16esc_pkg::CP_REPL;
        if (is_high && !end_of_string_i) begin
          pend_valid_d = 1'b1;
          pend_bits_d  = code_unit_i[9:0];
        end else if (is_high) begin
          nxt_valid_d = 1'b1;
          nxt_cp_d    = u16esc_pkg::CP_REPL[15:0];
        end else begin
          nxt_valid_d = 1'b1;
        end
      end
    end else if (is_high && !end_of_string_i) begin
      // Held for pairing: the working slot gets a silent code point.
      cur_cp_d     = '0;
      pend_valid_d = 1'b1;
      pend_bits_d  = code_unit_i[9:0];
    end else if (is_high || is_low) begin
      cur_cp_d = u16esc_pkg::CP_REPL;
    end
  end

  // Divide by ten through the reciprocal; the remainder is the next digit.
  logic [2*CW-1:0] prod;
  logic [QW-1:0]   quot;
  logic [CW-1:0]   quot10;
  logic [CW-1:0]   rem;
  assign prod   = {{CW{1'b0}}, work_q} * {{CW{1'b0}}, u16esc_pkg::RECIP_10};
  assign quot   = prod[u16esc_pkg::RECIP_SHIFT +: QW];
  assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem    = work_q - quot10;

  u16esc_pkg::kind_e kind;
  logic              nxt_emits;
  logic              cp_done;
  logic              dig_pop;
  logic [7:0]        byte_sel;
  assign kind      = u16esc_pkg::classify(cur_cp_q);
  assign nxt_emits = (u16esc_pkg::classify({5'b0, nxt_cp_q}) != u16esc_pkg::KIND_NONE);

  always_comb begin
    cp_done  = 1'b0;
    dig_pop  = 1'b0;
    byte_sel = u16esc_pkg::ent_byte(kind, pos_q[2:0]);
    if (kind == u16esc_pkg::KIND_NUM) begin
      if (pos_q == 4'd0) begin
        byte_sel = u16esc_pkg::CH_AMP;
      end else if (pos_q == 4'd1) begin
        byte_sel = u16esc_pkg::CH_HASH;
      end else if (pos_q == {1'b0, ndig_q} + 4'd2) begin
        byte_sel = u16esc_pkg::CH_SEMI;
        cp_done  = 1'b1;
      end else begin
        byte_sel = u16esc_pkg::CH_ZERO + {4'b0, dig_q[0]};
        dig_pop  = 1'b1;
      end
    end else begin
      cp_done = u16esc_pkg::ent_last(kind, pos_q[2:0]);
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_bits_q  <= '0;
      nxt_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      ndig_q       <= '0;
      pos_q        <= '0;
    end else begin
      if (cmd_i.load) begin
        pend_valid_q <= pend_valid_d;
        pend_bits_q  <= pend_bits_d;
        nxt_valid_q  <= nxt_valid_d;
      end else if (cmd_i.adv) begin
        nxt_valid_q <= 1'b0;
      end
      if (cmd_i.conv_init) begin
        ndig_q <= '0;
      end else if (cmd_i.conv_step) begin
        ndig_q <= ndig_q + 3'd1;
      end
      if (cmd_i.emit) begin
        pos_q <= cp_done ? 4'd0 : pos_q + 4'd1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_cp_q <= cur_cp_d;
      nxt_cp_q <= nxt_cp_d;
    end else if (cmd_i.adv) begin
      cur_cp_q <= {5'b0, nxt_cp_q};
    end
    if (cmd_i.conv_init) begin
      work_q <= cur_cp_q;
    end else if (cmd_i.conv_step) begin
      work_q <= {3'b000, quot};
    end
    // Digits form a stack: the most significant one ends up on top.
    if (cmd_i.conv_step) begin
      dig_q[0] <= rem[3:0];
      for (int i = 1; i < u16esc_pkg::NDIG; i++) begin
        dig_q[i] <= dig_q[i-1];
      end
    end else if (cmd_i.emit && dig_pop) begin
      for (int i = 0; i < u16esc_pkg::NDIG - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
    end
    if (cmd_i.emit) begin
      out_byte_q <= byte_sel;
      out_last_q <= cp_done && !(nxt_valid_q && nxt_emits);
    end
  end

  assign stat_o.kind      = kind;
  assign stat_o.nxt_valid = nxt_valid_q;
  assign stat_o.conv_last = (quot == '0);
  assign stat_o.cp_done   = cp_done;
  assign stat_o.out_free  = out_free;

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

// ----- rtl/utf16_xml_char_ref_escaper.sv -----
// Top level of the UTF-16 to XML character reference escaper.
// Joins u16esc_ctrl and u16esc_dpath; types come from u16esc_pkg.
`timescale 1ns / 1ps

// The block takes one UTF-16 code unit per accepted word and delivers its
// XML-escaped text as a run of ASCII bytes, one byte per word, with
// last_of_run_o marking the final byte of each run. Surrogate pairs are
// joined, a stray or unpaired surrogate becomes U+FFFD, the characters
// & < > and the double quote become named entities, and other code points
// from 32 up (except 127) become decimal references. A word that produces
// no bytes, such as a held high surrogate or a control character, still
// passes through the decode state. A decimal reference is built in two
// phases: the divide-by-ten unit produces its digits one at a time, then
// the bytes are written out one at a time; a word that also flushes an
// unpaired high surrogate first emits the reference of that replacement.
// Output stalls hold the byte phase; the last byte of a run may wait in
// the output register while the next word is accepted.
module utf16_xml_char_ref_escaper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_string_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);

  u16esc_pkg::ctrl_cmd_t cmd;
  u16esc_pkg::dp_stat_t  stat;

  u16esc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  u16esc_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .code_unit_i     (code_unit_i),
    .end_of_string_i (end_of_string_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .out_byte_o      (out_byte_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ----- rtl/u16esc_chk.sv -----
// Port-level checker for the escaper, attached to the top level by bind.
// Depends on u16esc_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
`include "utf16_xml_char_ref_escaper_defines.svh"

module u16esc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [15:0] code_unit_i,
  input logic        end_of_string_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        last_of_run_o
);

  logic out_last_shown;
  logic out_open_shown;
  logic in_taken;

  assign out_last_shown = out_valid_o && last_of_run_o;
  assign out_open_shown = out_valid_o && (out_byte_o == u16esc_pkg::CH_AMP ||
                                          out_byte_o == u16esc_pkg::CH_HASH);
  assign in_taken       = in_valid_i && !in_stall_o;

  // A stalled output word must stay offered.
  `U16ESC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)

  // Every run ends with the semicolon that closes a reference.
  `U16ESC_ASSERT_NOW(a_last_semi, clk_i, rst_ni, out_last_shown, out_byte_o == u16esc_pkg::CH_SEMI)

  // A run never ends on an opening ampersand or hash.
  `U16ESC_ASSERT_NOW(a_open_not_last, clk_i, rst_ni, out_open_shown, !last_of_run_o)

  // After a word is accepted, the input stalls while that word is decoded.
  `U16ESC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_taken, in_stall_o)

endmodule

bind utf16_xml_char_ref_escaper u16esc_chk u_chk (.*);
